// ----- rtl/core/heu_pkg.sv -----
// Types, constants and entity tables shared by the entity unescaper modules.
`timescale 1ns / 1ps

package heu_pkg;

   localparam logic [7:0] CHAR_AMP  = 8'h26;
   localparam logic [7:0] CHAR_HASH = 8'h23;
   localparam logic [7:0] CHAR_SEMI = 8'h3B;
   localparam logic [7:0] CHAR_XL   = 8'h78;
   localparam logic [7:0] CHAR_XU   = 8'h58;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_AMP,
      PH_NAME,
      PH_NUM
   } phase_type;

   typedef enum logic [1:0] {
      ENT_AMP,
      ENT_LT,
      ENT_GT,
      ENT_QUOT
   } ent_type;

   typedef enum logic [1:0] {
      ACT_EMIT,
      ACT_HOLD,
      ACT_OPEN
   } act_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_PRE_RD,
      BK_PRE_OUT,
      BK_ACT,
      BK_POST_RD,
      BK_POST_OUT
   } back_state_type;

   typedef struct packed {
      logic       flush_pre;
      act_type    act;
      logic [7:0] data;
      logic       last;
   } cmd_type;

   function automatic logic [2:0] ent_len(input ent_type k);
      logic [2:0] len;
      case (k)
         ENT_AMP:  len = 3'd3;
         ENT_LT:   len = 3'd2;
         ENT_GT:   len = 3'd2;
         ENT_QUOT: len = 3'd4;
         default:  len = 3'd0;
      endcase
      return len;
   endfunction

   function automatic logic [7:0] ent_value(input ent_type k);
      logic [7:0] v;
      case (k)
         ENT_AMP:  v = 8'h26;
         ENT_LT:   v = 8'h3C;
         ENT_GT:   v = 8'h3E;
         ENT_QUOT: v = 8'h22;
         default:  v = 8'h00;
      endcase
      return v;
   endfunction

   function automatic logic [7:0] ent_char(input ent_type k, input logic [1:0] pos);
      logic [7:0] c;
      c = 8'h00;
      case (k)
         ENT_AMP: begin
            case (pos)
               2'd0:    c = 8'h61;
               2'd1:    c = 8'h6D;
               2'd2:    c = 8'h70;
               default: c = 8'h00;
            endcase
         end
         ENT_LT: begin
            case (pos)
               2'd0:    c = 8'h6C;
               2'd1:    c = 8'h74;
               default: c = 8'h00;
            endcase
         end
         ENT_GT: begin
            case (pos)
               2'd0:    c = 8'h67;
               2'd1:    c = 8'h74;
               default: c = 8'h00;
            endcase
         end
         ENT_QUOT: begin
            case (pos)
               2'd0:    c = 8'h71;
               2'd1:    c = 8'h75;
               2'd2:    c = 8'h6F;
               2'd3:    c = 8'h74;
               default: c = 8'h00;
            endcase
         end
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

// ----- rtl/core/heu_front.sv -----
// Front end: accepts text bytes, parses entity candidates and issues commands.
`timescale 1ns / 1ps

module heu_front
   import heu_pkg::*;
#(
   parameter int BUF_DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // in_byte
   input  logic       req_tlast,   // in_last
   output logic       push,
   output cmd_type    push_cmd,
   input  logic       queue_full
);

   localparam int CNT_W = $clog2(BUF_DEPTH);

   typedef enum logic [1:0] {
      ADV_HOLD,
      ADV_DONE,
      ADV_FAIL
   } adv_type;

   phase_type         phase_ff, phase_in, hold_phase;
   ent_type           kind_ff, kind_in, hold_kind;
   logic [CNT_W-1:0]  cnt_ff, cnt_in, pos;
   logic [31:0]       acc_ff, acc_in, acc_next;
   logic              hex_ff, hex_in, hold_hex;
   adv_type           adv;
   logic [7:0]        b, done_val;
   logic [3:0]        dval;
   logic              is_digit, can_hold, accept;

   assign b          = req_tdata;
   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;
   assign push       = accept;
   assign can_hold   = cnt_ff < CNT_W'(BUF_DEPTH - 1);
   assign pos        = cnt_ff - CNT_W'(1);

   always_comb begin
      is_digit = 1'b0;
      dval     = 4'd0;
      if (b inside {[8'h30:8'h39]}) begin
         is_digit = 1'b1;
         dval     = 4'(b - 8'h30);
      end else if (hex_ff && (b inside {[8'h61:8'h66]})) begin
         is_digit = 1'b1;
         dval     = 4'(b - 8'h57);
      end else if (hex_ff && (b inside {[8'h41:8'h46]})) begin
         is_digit = 1'b1;
         dval     = 4'(b - 8'h37);
      end
      if (hex_ff) begin
         acc_next = {acc_ff[27:0], 4'd0} + {28'd0, dval};
      end else begin
         acc_next = {acc_ff[28:0], 3'd0} + {acc_ff[30:0], 1'b0} + {28'd0, dval};
      end
   end

   always_comb begin
      adv        = ADV_FAIL;
      hold_phase = phase_ff;
      hold_kind  = kind_ff;
      hold_hex   = hex_ff;
      done_val   = 8'h00;
      case (phase_ff)
         PH_AMP: begin
            if (b == CHAR_HASH) begin
               adv        = ADV_HOLD;
               hold_phase = PH_NUM;
            end else if (b == ent_char(ENT_AMP, 2'd0)) begin
               adv        = ADV_HOLD;
               hold_phase = PH_NAME;
               hold_kind  = ENT_AMP;
            end else if (b == ent_char(ENT_LT, 2'd0)) begin
               adv        = ADV_HOLD;
               hold_phase = PH_NAME;
               hold_kind  = ENT_LT;
            end else if (b == ent_char(ENT_GT, 2'd0)) begin
               adv        = ADV_HOLD;
               hold_phase = PH_NAME;
               hold_kind  = ENT_GT;
            end else if (b == ent_char(ENT_QUOT, 2'd0)) begin
               adv        = ADV_HOLD;
               hold_phase = PH_NAME;
               hold_kind  = ENT_QUOT;
            end
         end
         PH_NAME: begin
            if (pos == CNT_W'(ent_len(kind_ff)) && b == CHAR_SEMI) begin
               adv      = ADV_DONE;
               done_val = ent_value(kind_ff);
            end else if (pos < CNT_W'(ent_len(kind_ff)) &&
                         b == ent_char(kind_ff, pos[1:0])) begin
               adv = ADV_HOLD;
            end
         end
         PH_NUM: begin
            if (b == CHAR_SEMI) begin
               if (acc_ff != 32'd0 && acc_ff[31:8] == 24'd0) begin
                  adv      = ADV_DONE;
                  done_val = acc_ff[7:0];
               end
            end else if (!hex_ff && cnt_ff == CNT_W'(2) && (b == CHAR_XL || b == CHAR_XU)) begin
               adv      = ADV_HOLD;
               hold_hex = 1'b1;
            end else if (is_digit) begin
               adv = ADV_HOLD;
            end
         end
         default: adv = ADV_FAIL;
      endcase
      if (adv == ADV_HOLD && !can_hold) begin
         adv = ADV_FAIL;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      kind_in  = kind_ff;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      hex_in   = hex_ff;
      push_cmd = '{flush_pre: 1'b0, act: ACT_EMIT, data: b, last: req_tlast};
      if (phase_ff == PH_IDLE) begin
         if (b == CHAR_AMP) begin
            push_cmd.act = ACT_OPEN;
            phase_in     = PH_AMP;
            cnt_in       = CNT_W'(1);
            acc_in       = 32'd0;
            hex_in       = 1'b0;
         end
      end else begin
         case (adv)
            ADV_HOLD: begin
               push_cmd.act = ACT_HOLD;
               phase_in     = hold_phase;
               kind_in      = hold_kind;
               cnt_in       = cnt_ff + CNT_W'(1);
               hex_in       = hold_hex;
               if (phase_ff == PH_NUM && !(hold_hex && !hex_ff)) begin
                  acc_in = acc_next;
               end
            end
            ADV_DONE: begin
               push_cmd.data = done_val;
               phase_in      = PH_IDLE;
               cnt_in        = '0;
               acc_in        = 32'd0;
               hex_in        = 1'b0;
            end
            default: begin
               push_cmd.flush_pre = 1'b1;
               acc_in             = 32'd0;
               hex_in             = 1'b0;
               if (b == CHAR_AMP) begin
                  push_cmd.act = ACT_OPEN;
                  phase_in     = PH_AMP;
                  cnt_in       = CNT_W'(1);
               end else begin
                  phase_in = PH_IDLE;
                  cnt_in   = '0;
               end
            end
         endcase
      end
      if (req_tlast) begin
         phase_in = PH_IDLE;
         cnt_in   = '0;
         acc_in   = 32'd0;
         hex_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         kind_ff  <= ENT_AMP;
         cnt_ff   <= '0;
         acc_ff   <= 32'd0;
         hex_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         kind_ff  <= kind_in;
         cnt_ff   <= cnt_in;
         acc_ff   <= acc_in;
         hex_ff   <= hex_in;
      end
   end

`ifndef SYNTHESIS
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> cnt_ff == '0 && acc_ff == 32'd0 && !hex_ff)
      else $error("front idle with candidate state left");
`endif

endmodule

// ----- rtl/core/heu_queue.sv -----
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps

module heu_queue
   import heu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output cmd_type head,
   output logic    nonempty
);

   cmd_type           slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full     = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign nonempty = count_ff != '0;
   assign head     = slots_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
      end
   end

`ifndef SYNTHESIS
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("queue popped while empty");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> count_ff != QCNT_W'(QUEUE_DEPTH) || pop)
      else $error("queue pushed while full");
`endif

endmodule

// ----- rtl/core/heu_back.sv -----
// Back end: holds candidate bytes, replays them and drives the result word.
`timescale 1ns / 1ps

module heu_back
   import heu_pkg::*;
#(
   parameter int BUF_DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    head,
   input  logic       nonempty,
   output logic       pop,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // out_byte
   output logic       rsp_tlast    // out_last
);

   localparam int CNT_W = $clog2(BUF_DEPTH);

   back_state_type   state_ff, state_in;
   cmd_type          cmd_ff, cmd_in, cur;
   logic [CNT_W-1:0] cnt_ff, cnt_in, idx_ff, idx_in, wr_addr, cnt_top;
   logic [7:0]       held_mem [BUF_DEPTH];
   logic [7:0]       rd_data_ff, wr_data, out_data;
   logic             wr_en, out_load, out_last, out_free, finished, run;
   logic             valid_ff, valid_in, last_ff;
   logic [7:0]       data_ff;

   assign out_free   = !valid_ff || rsp_tready;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;
   assign cur        = (state_ff == BK_IDLE) ? head : cmd_ff;
   assign cnt_top    = cnt_ff - CNT_W'(1);

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      pop      = 1'b0;
      wr_en    = 1'b0;
      wr_addr  = cnt_ff;
      wr_data  = cur.data;
      out_load = 1'b0;
      out_data = cur.data;
      out_last = 1'b0;
      finished = 1'b0;
      run      = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (nonempty) begin
               if (head.flush_pre && cnt_ff != '0) begin
                  pop      = 1'b1;
                  cmd_in   = head;
                  idx_in   = '0;
                  state_in = BK_PRE_RD;
               end else begin
                  run = 1'b1;
               end
            end
         end
         BK_PRE_RD:  state_in = BK_PRE_OUT;
         BK_POST_RD: state_in = BK_POST_OUT;
         BK_PRE_OUT: begin
            if (out_free) begin
               out_load = 1'b1;
               out_data = rd_data_ff;
               if (idx_ff == cnt_top) begin
                  cnt_in   = '0;
                  state_in = BK_ACT;
               end else begin
                  idx_in   = idx_ff + CNT_W'(1);
                  state_in = BK_PRE_RD;
               end
            end
         end
         BK_ACT: run = 1'b1;
         BK_POST_OUT: begin
            if (out_free) begin
               out_load = 1'b1;
               out_data = rd_data_ff;
               if (idx_ff == cnt_top) begin
                  out_last = cmd_ff.last;
                  cnt_in   = '0;
                  state_in = BK_IDLE;
               end else begin
                  idx_in   = idx_ff + CNT_W'(1);
                  state_in = BK_POST_RD;
               end
            end
         end
         default: state_in = BK_IDLE;
      endcase

      if (run) begin
         case (cur.act)
            ACT_EMIT: begin
               if (out_free) begin
                  out_load = 1'b1;
                  out_data = cur.data;
                  out_last = cur.last;
                  cnt_in   = '0;
                  finished = 1'b1;
                  state_in = BK_IDLE;
               end
            end
            ACT_HOLD: begin
               wr_en    = 1'b1;
               wr_addr  = cnt_ff;
               wr_data  = cur.data;
               cnt_in   = cnt_ff + CNT_W'(1);
               finished = 1'b1;
            end
            ACT_OPEN: begin
               wr_en    = 1'b1;
               wr_addr  = '0;
               wr_data  = CHAR_AMP;
               cnt_in   = CNT_W'(1);
               finished = 1'b1;
            end
            default: finished = 1'b1;
         endcase
         if (finished && cur.act != ACT_EMIT) begin
            cmd_in   = cur;
            idx_in   = '0;
            state_in = cur.last ? BK_POST_RD : BK_IDLE;
         end
         if (state_ff == BK_IDLE) begin
            pop = finished;
         end
      end

      valid_in = valid_ff;
      if (out_load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         held_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= held_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         data_ff <= out_data;
         last_ff <= out_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         cnt_ff   <= '0;
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
   end

`ifndef SYNTHESIS
   a_replay_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_PRE_OUT || state_ff == BK_POST_OUT) |-> cnt_ff != '0)
      else $error("replay with empty hold buffer");
   a_post_only_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_POST_RD || state_ff == BK_POST_OUT) |-> cmd_ff.last)
      else $error("end-of-text flush without final word");
`endif

endmodule

// ----- rtl/core/html_entity_unescaper_core.sv -----
// A plain byte accepted at the input passes through the command queue into the output
// register on rsp_tdata. Throughput: one byte per cycle for plain text and held or
// decoded entity bytes while the queue has room and rsp_tready is high. As the hold
// buffer read is registered, a replay alternates a read and an output state per byte,
// plus BK_ACT before a failing word; the 4-entry queue buffers commands. Reset
// (synchronous, active high) clears parser, queue, output control, not the hold buffer.
`timescale 1ns / 1ps

module html_entity_unescaper_core
   import heu_pkg::*;
#(
   parameter int BUF_DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // in_byte
   input  logic       req_tlast,   // in_last
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // out_byte
   output logic       rsp_tlast    // out_last
);

   logic    push, queue_full, pop, nonempty;
   cmd_type push_cmd, head;

   heu_front #(
      .BUF_DEPTH(BUF_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push       (push),
      .push_cmd   (push_cmd),
      .queue_full (queue_full)
   );

   heu_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (queue_full),
      .pop      (pop),
      .head     (head),
      .nonempty (nonempty)
   );

   heu_back #(
      .BUF_DEPTH(BUF_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .nonempty   (nonempty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
